[rtl/mpeg1_layer2_frame_scanner_assert.svh]
// Assertion macros used by the checker file.
`ifndef MPEG1_LAYER2_FRAME_SCANNER_ASSERT_SVH
`define MPEG1_LAYER2_FRAME_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mlfs_pkg.sv]
package mlfs_pkg;

    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_VERSION = 3'd1,
        KIND_LAYER   = 3'd2,
        KIND_RATE    = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] frame_number;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic [10:0] frame_bytes;
        logic [5:0]  duration_ms;
        logic [31:0] start_time_ms;
        logic [31:0] garbage_bytes;
    } job_t;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]  SYNC2_MASK     = 8'hE0;
    localparam logic [7:0]  VERSION_MASK   = 8'h18;
    localparam logic [7:0]  LAYER_MASK     = 8'h06;
    localparam logic [7:0]  LAYER2_CODE    = 8'h04;
    localparam logic [10:0] HEADER_BYTES   = 11'd4;
    localparam logic [31:0] SPACING_RESET  = 32'd2000000;

    function automatic logic [8:0] bitrate_of(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd1:    r = 9'd32;
            4'd2:    r = 9'd48;
            4'd3:    r = 9'd56;
            4'd4:    r = 9'd64;
            4'd5:    r = 9'd80;
            4'd6:    r = 9'd96;
            4'd7:    r = 9'd112;
            4'd8:    r = 9'd128;
            4'd9:    r = 9'd160;
            4'd10:   r = 9'd192;
            4'd11:   r = 9'd224;
            4'd12:   r = 9'd256;
            4'd13:   r = 9'd320;
            4'd14:   r = 9'd384;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sample_rate_of(input logic [1:0] idx);
        logic [15:0] r;
        case (idx)
            2'd0:    r = 16'd44100;
            2'd1:    r = 16'd48000;
            2'd2:    r = 16'd32000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Frame length without padding: 144000 * bitrate / sample rate.
    function automatic logic [10:0] frame_base_of(input logic [3:0] br_idx,
                                                  input logic [1:0] sr_idx);
        logic [10:0] r;
        logic [12:0] br;
        br = {4'd0, bitrate_of(br_idx)};
        case (sr_idx)
            2'd0:
            begin
                case (br_idx)
                    4'd1:    r = 11'd104;
                    4'd2:    r = 11'd156;
                    4'd3:    r = 11'd182;
                    4'd4:    r = 11'd208;
                    4'd5:    r = 11'd261;
                    4'd6:    r = 11'd313;
                    4'd7:    r = 11'd365;
                    4'd8:    r = 11'd417;
                    4'd9:    r = 11'd522;
                    4'd10:   r = 11'd626;
                    4'd11:   r = 11'd731;
                    4'd12:   r = 11'd835;
                    4'd13:   r = 11'd1044;
                    4'd14:   r = 11'd1253;
                    default: r = 11'd0;
                endcase
            end
            2'd1:    r = 11'(br * 13'd3);
            2'd2:    r = 11'((br * 13'd9) >> 1);
            default: r = 11'd0;
        endcase
        return r;
    endfunction

    // Whole milliseconds per frame; padding never changes the result.
    function automatic logic [5:0] duration_of(input logic [1:0] sr_idx);
        logic [5:0] r;
        case (sr_idx)
            2'd0:    r = 6'd26;
            2'd1:    r = 6'd24;
            2'd2:    r = 6'd36;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/mlfs_front.sv]
module mlfs_front #(
    parameter int POSITION_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     q_full,
    input  logic [7:0]               data_byte,
    input  logic                     stream_end,
    output logic                     push,
    output mlfs_pkg::job_t           push_job,
    output logic [POSITION_BITS-1:0] push_offset
);

    typedef enum logic [4:0] {
        MODE_HUNT = 5'b00001,
        MODE_HDR1 = 5'b00010,
        MODE_HDR2 = 5'b00100,
        MODE_HDR3 = 5'b01000,
        MODE_SKIP = 5'b10000
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] sync_reg, sync_next;
    logic [7:0]               hdr0_reg, hdr0_next;
    logic [7:0]               hdr1_reg, hdr1_next;
    logic [10:0]              left_reg, left_next;
    logic [23:0]              count_reg, count_next;
    logic [31:0]              total_reg, total_next;
    logic [31:0]              garbage_reg, garbage_next;

    logic        accept;
    logic [8:0]  br;
    logic [15:0] sr;
    logic [10:0] len;
    logic [5:0]  ms;
    logic [10:0] left_dec;

    assign accept = in_valid && !q_full;
    assign br     = mlfs_pkg::bitrate_of(hdr1_reg[7:4]);
    assign sr     = mlfs_pkg::sample_rate_of(hdr1_reg[3:2]);
    assign len    = mlfs_pkg::frame_base_of(hdr1_reg[7:4], hdr1_reg[3:2])
                    + {10'd0, hdr1_reg[1]};
    assign ms     = mlfs_pkg::duration_of(hdr1_reg[3:2]);
    assign left_dec = (left_reg != 11'd0) ? left_reg - 11'd1 : 11'd0;

    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        sync_next    = sync_reg;
        hdr0_next    = hdr0_reg;
        hdr1_next    = hdr1_reg;
        left_next    = left_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        garbage_next = garbage_reg;
        push         = 1'b0;
        push_job     = '0;
        push_offset  = sync_reg;

        if (accept)
        begin
            if (stream_end)
            begin
                push                   = 1'b1;
                push_job.kind          = mlfs_pkg::KIND_END;
                push_job.frame_number  = count_reg;
                push_job.start_time_ms = total_reg;
                push_job.garbage_bytes = garbage_reg;
                push_offset            = pos_reg;
                mode_next              = MODE_HUNT;
                garbage_next           = 32'd0;
            end
            else
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
                case (mode_reg)
                    MODE_HUNT:
                    begin
                        if (data_byte == mlfs_pkg::SYNC_BYTE)
                        begin
                            sync_next = pos_reg;
                            mode_next = MODE_HDR1;
                        end
                        else
                        begin
                            garbage_next = garbage_reg + 32'd1;
                        end
                    end
                    MODE_HDR1:
                    begin
                        if ((data_byte & mlfs_pkg::SYNC2_MASK) == mlfs_pkg::SYNC2_MASK)
                        begin
                            hdr0_next = data_byte;
                            mode_next = MODE_HDR2;
                        end
                        else
                        begin
                            garbage_next = garbage_reg + 32'd1;
                            mode_next    = MODE_HUNT;
                        end
                    end
                    MODE_HDR2:
                    begin
                        hdr1_next = data_byte;
                        mode_next = MODE_HDR3;
                    end
                    MODE_HDR3:
                    begin
                        // The fourth header byte carries nothing that is decoded here.
                        push                    = 1'b1;
                        count_next              = count_reg + 24'd1;
                        push_job.frame_number   = count_reg + 24'd1;
                        push_job.bitrate_kbps   = br;
                        push_job.sample_rate_hz = sr;
                        push_job.start_time_ms  = total_reg;
                        push_job.garbage_bytes  = garbage_reg;
                        garbage_next            = 32'd0;
                        mode_next               = MODE_HUNT;
                        if ((hdr0_reg & mlfs_pkg::VERSION_MASK) != mlfs_pkg::VERSION_MASK)
                        begin
                            push_job.kind = mlfs_pkg::KIND_VERSION;
                        end
                        else if ((hdr0_reg & mlfs_pkg::LAYER_MASK) != mlfs_pkg::LAYER2_CODE)
                        begin
                            push_job.kind = mlfs_pkg::KIND_LAYER;
                        end
                        else if (br == 9'd0 || sr == 16'd0)
                        begin
                            push_job.kind = mlfs_pkg::KIND_RATE;
                        end
                        else
                        begin
                            push_job.kind        = mlfs_pkg::KIND_FRAME;
                            push_job.frame_bytes = len;
                            push_job.duration_ms = ms;
                            total_next           = total_reg + {26'd0, ms};
                            left_next            = len - mlfs_pkg::HEADER_BYTES;
                            mode_next            = MODE_SKIP;
                        end
                    end
                    MODE_SKIP:
                    begin
                        left_next = left_dec;
                        if (left_dec == 11'd0)
                        begin
                            mode_next = MODE_HUNT;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_HUNT;
            pos_reg     <= '0;
            sync_reg    <= '0;
            hdr0_reg    <= 8'd0;
            hdr1_reg    <= 8'd0;
            left_reg    <= 11'd0;
            count_reg   <= 24'd0;
            total_reg   <= 32'd0;
            garbage_reg <= 32'd0;
        end
        else
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            sync_reg    <= sync_next;
            hdr0_reg    <= hdr0_next;
            hdr1_reg    <= hdr1_next;
            left_reg    <= left_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            garbage_reg <= garbage_next;
        end
    end

endmodule

[rtl/mlfs_queue.sv]
module mlfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/mlfs_back.sv]
module mlfs_back #(
    parameter int POSITION_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     mark_spacing_wr_en,
    input  logic [31:0]              mark_spacing_wr_data,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  mlfs_pkg::job_t           job,
    input  logic [POSITION_BITS-1:0] job_offset,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               result_kind,
    output logic [31:0]              frame_offset,
    output logic [23:0]              frame_number,
    output logic [8:0]               bitrate_kbps,
    output logic [15:0]              sample_rate_hz,
    output logic [10:0]              frame_bytes,
    output logic [5:0]               duration_ms,
    output logic [31:0]              start_time_ms,
    output logic [31:0]              garbage_bytes,
    output logic                     index_mark
);

    localparam int STEP_BITS = $clog2(POSITION_BITS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [31:0]              spacing_reg;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [POSITION_BITS-1:0] quo_reg, quo_next;
    logic [31:0]              rem_reg, rem_next;
    mlfs_pkg::job_t           job_reg, job_next;
    logic [31:0]              off_reg, off_next;
    logic [8:0]               last_br_reg, last_br_next;
    logic [15:0]              last_sr_reg, last_sr_next;
    logic [31:0]              last_blk_reg, last_blk_next;
    logic                     out_valid_reg, out_valid_next;
    mlfs_pkg::job_t           out_job_reg, out_job_next;
    logic [31:0]              out_off_reg, out_off_next;
    logic                     out_mark_reg, out_mark_next;

    logic        out_free;
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        fits;
    logic [31:0] blk;

    assign out_free = !out_valid_reg || !out_stall;

    // Restoring division of the sync offset by the spacing, one quotient bit a cycle.
    assign shifted = {rem_reg, quo_reg[POSITION_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, spacing_reg};
    assign fits    = !diff[33];
    assign blk     = (spacing_reg == 32'd0) ? 32'd0 : 32'(quo_reg);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        job_next       = job_reg;
        off_next       = off_reg;
        last_br_next   = last_br_reg;
        last_sr_next   = last_sr_reg;
        last_blk_next  = last_blk_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_job_next   = out_job_reg;
        out_off_next   = out_off_reg;
        out_mark_next  = out_mark_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && (job.kind == mlfs_pkg::KIND_FRAME || out_free))
                begin
                    q_pop = 1'b1;
                    if (job.kind == mlfs_pkg::KIND_FRAME)
                    begin
                        job_next   = job;
                        off_next   = 32'(job_offset);
                        quo_next   = job_offset;
                        rem_next   = 32'd0;
                        step_next  = STEP_BITS'(POSITION_BITS - 1);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_job_next   = job;
                        out_off_next   = 32'(job_offset);
                        out_mark_next  = 1'b0;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? diff[31:0] : shifted[31:0];
                quo_next  = {quo_reg[POSITION_BITS-2:0], fits};
                step_next = step_reg - STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_job_next   = job_reg;
                    out_off_next   = off_reg;
                    out_mark_next  = 1'b0;
                    if (job_reg.bitrate_kbps != last_br_reg
                        || job_reg.sample_rate_hz != last_sr_reg)
                    begin
                        out_mark_next = 1'b1;
                        last_br_next  = job_reg.bitrate_kbps;
                        last_sr_next  = job_reg.sample_rate_hz;
                        last_blk_next = blk;
                    end
                    else if (blk != last_blk_reg)
                    begin
                        out_mark_next = 1'b1;
                        last_blk_next = blk;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spacing_reg   <= mlfs_pkg::SPACING_RESET;
            last_br_reg   <= 9'd0;
            last_sr_reg   <= 16'd0;
            last_blk_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_br_reg   <= last_br_next;
            last_sr_reg   <= last_sr_next;
            last_blk_reg  <= last_blk_next;
            out_valid_reg <= out_valid_next;
            if (mark_spacing_wr_en)
            begin
                spacing_reg <= mark_spacing_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        job_reg      <= job_next;
        off_reg      <= off_next;
        out_job_reg  <= out_job_next;
        out_off_reg  <= out_off_next;
        out_mark_reg <= out_mark_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_job_reg.kind;
    assign frame_offset   = out_off_reg;
    assign frame_number   = out_job_reg.frame_number;
    assign bitrate_kbps   = out_job_reg.bitrate_kbps;
    assign sample_rate_hz = out_job_reg.sample_rate_hz;
    assign frame_bytes    = out_job_reg.frame_bytes;
    assign duration_ms    = out_job_reg.duration_ms;
    assign start_time_ms  = out_job_reg.start_time_ms;
    assign garbage_bytes  = out_job_reg.garbage_bytes;
    assign index_mark     = out_mark_reg;

endmodule

[rtl/mpeg1_layer2_frame_scanner.sv]
// MPEG-1 Layer II frame scanner.
// Input channel: in_valid / in_stall with data_byte, or stream_end high for a
// transfer that carries no byte and asks for the end summary. Output channel:
// out_valid / out_stall with one result per decoded header and one per end.
// mark_spacing is written through mark_spacing_wr_en / mark_spacing_wr_data;
// the user must write it only while idle, which the block does not enforce.
// The front parser takes one byte every cycle unless in_stall is high and
// pushes header and end results into a QUEUE_DEPTH entry queue. The back end
// sends each frame result through the bit-serial divider that finds the offset
// block and each error or end result straight to the output register. A frame
// result passes the queue, the divider states and the output register, other
// results the queue and the output register. Since frames hold at least 96
// bytes, the input runs at one byte per cycle for normal streams; a burst of
// header errors can fill the queue, and in_stall then rises until the back end
// drains. Reset clears all counters, returns to sync hunting, empties the queue
// and sets mark_spacing to 2000000. While out_stall is high the result holds
// and the back end waits to output; once the queue is full the input stalls too.
module mpeg1_layer2_frame_scanner #(
    parameter int POSITION_BITS = 32,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mark_spacing_wr_en,
    input  logic [31:0] mark_spacing_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [31:0] frame_offset,
    output logic [23:0] frame_number,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic [10:0] frame_bytes,
    output logic [5:0]  duration_ms,
    output logic [31:0] start_time_ms,
    output logic [31:0] garbage_bytes,
    output logic        index_mark
);

    localparam int JOB_BITS   = $bits(mlfs_pkg::job_t);
    localparam int ENTRY_BITS = JOB_BITS + POSITION_BITS;

    logic                     push, pop, q_full, q_empty;
    mlfs_pkg::job_t           push_job, pop_job;
    logic [POSITION_BITS-1:0] push_offset, pop_offset;
    logic [ENTRY_BITS-1:0]    push_entry, pop_entry;

    assign in_stall   = q_full;
    assign push_entry = {push_offset, push_job};
    assign pop_job    = mlfs_pkg::job_t'(pop_entry[JOB_BITS-1:0]);
    assign pop_offset = pop_entry[ENTRY_BITS-1:JOB_BITS];

    mlfs_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .q_full     (q_full),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .push       (push),
        .push_job   (push_job),
        .push_offset(push_offset)
    );

    mlfs_queue #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_entry),
        .pop      (pop),
        .pop_data (pop_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    mlfs_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .mark_spacing_wr_en  (mark_spacing_wr_en),
        .mark_spacing_wr_data(mark_spacing_wr_data),
        .q_empty             (q_empty),
        .q_pop               (pop),
        .job                 (pop_job),
        .job_offset          (pop_offset),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .result_kind         (result_kind),
        .frame_offset        (frame_offset),
        .frame_number        (frame_number),
        .bitrate_kbps        (bitrate_kbps),
        .sample_rate_hz      (sample_rate_hz),
        .frame_bytes         (frame_bytes),
        .duration_ms         (duration_ms),
        .start_time_ms       (start_time_ms),
        .garbage_bytes       (garbage_bytes),
        .index_mark          (index_mark)
    );

endmodule

[rtl/mlfs_checker.sv]
`include "mpeg1_layer2_frame_scanner_assert.svh"

module mlfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  result_kind,
    input logic [31:0] frame_offset,
    input logic [10:0] frame_bytes,
    input logic [5:0]  duration_ms,
    input logic        index_mark
);

    logic is_frame;

    assign is_frame = (result_kind == mlfs_pkg::KIND_FRAME);

    `MLFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    `MLFS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(frame_offset) && $stable(result_kind), "stalled result changed")

    // Error and end results carry no frame length, duration or mark.
    `MLFS_ASSERT_NOW(a_nonframe_zero, out_valid && !is_frame, frame_bytes == 11'd0 && duration_ms == 6'd0 && !index_mark, "non-frame result has frame fields")

    // A decoded frame is at least 96 bytes and lasts 24, 26 or 36 ms.
    `MLFS_ASSERT_NOW(a_frame_sane, out_valid && is_frame, frame_bytes >= 11'd96 && (duration_ms == 6'd24 || duration_ms == 6'd26 || duration_ms == 6'd36), "frame length or duration out of range")

endmodule

bind mpeg1_layer2_frame_scanner mlfs_checker u_mlfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .frame_offset(frame_offset),
    .frame_bytes (frame_bytes),
    .duration_ms (duration_ms),
    .index_mark  (index_mark)
);
